FILE: rtl/square_wave_sample_generator_macros.svh
// Assertion macros for the square wave sample generator.
// Included by the controller and datapath; no other dependencies.
`ifndef SQUARE_WAVE_SAMPLE_GENERATOR_MACROS_SVH
`define SQUARE_WAVE_SAMPLE_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define SWSG_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

`define SWSG_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`else

`define SWSG_ASSERT(lbl, clk_s, rst_s, prop, msg)

`define SWSG_ASSERT_ALWAYS(lbl, clk_s, prop, msg)

`endif

`endif

FILE: rtl/swsg_pkg.sv
// Shared types and constants for the square wave sample generator.
// No dependencies.
`timescale 1ns / 1ps

package swsg_pkg;

  localparam int COUNT_WIDTH_DEF = 16;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int SAMPLE_W    = 8;
  localparam int INDEX_W     = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int RATE_W      = 16;
  localparam int FREQ_W      = 16;
  localparam int LEVEL_W     = 8;
  localparam int DUTY_W      = 17;
  localparam int DUTY_FRAC_W = 16;

  localparam logic [RATE_W-1:0]  SAMPLE_RATE_RST = 16'd4000;
  localparam logic [FREQ_W-1:0]  TARGET_FREQ_RST = 16'd200;
  localparam logic [LEVEL_W-1:0] LOW_LEVEL_RST   = 8'd0;
  localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RST  = 8'd255;
  localparam logic [DUTY_W-1:0]  DUTY_RST        = 17'd32768;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SAMPLE_RATE = 3'd0,
    REG_TARGET_FREQ = 3'd1,
    REG_LOW_LEVEL   = 3'd2,
    REG_HIGH_LEVEL  = 3'd3,
    REG_DUTY_Q16    = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DSEL_GCD,
    DSEL_N,
    DSEL_D,
    DSEL_Q
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_GCD_CHK,
    ST_GCD_WAIT,
    ST_N_WAIT,
    ST_D_WAIT,
    ST_Q_START,
    ST_Q_WAIT,
    ST_PLOAD,
    ST_MUL,
    ST_HIGH,
    ST_STEP,
    ST_PUSH
  } swsg_state_t;

  typedef struct packed {
    logic     load_setup;
    logic     div_start;
    div_sel_t div_sel;
    logic     gcd_shift;
    logic     cap_n;
    logic     cap_d;
    logic     cap_q;
    logic     period_load;
    logic     mul;
    logic     high_load;
    logic     step;
  } swsg_cmd_t;

  typedef struct packed {
    logic setup_done;
    logic gcd_b_zero;
    logic div_done;
    logic new_period;
  } swsg_sts_t;

endpackage

FILE: rtl/square_wave_sample_generator.sv
// Square wave sample generator, top level: controller, datapath and output register.
// Depends on swsg_pkg, swsg_ctrl and swsg_datapath.
//
// Each item on the in_ channel yields one item on the out_ channel. in_tdata bit 0 is
// restart: it, or the first item after reset, recomputes the buffer geometry
// (Euclid gcd and three divisions on one shared bit-serial divider) and starts at
// sample zero. Configuration writes on the cfg_ channel are taken every cycle.
// An item that starts no new period is stepped and then pushed; an item that starts a
// new period also loads the period length, forms the duty multiply and loads the high
// count before the push. A setup runs one division per Euclid step and then three
// divisions on the divider, which yields one quotient bit per cycle.
// Reset loads the register defaults and empties the output register; the geometry
// is then computed on the first item. When out_tready is low the finished item
// waits in the output register, the next item is still accepted and processed,
// and its result waits in the datapath until the register frees.
`timescale 1ns / 1ps

module square_wave_sample_generator #(
  parameter int COUNT_WIDTH = swsg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [swsg_pkg::IN_TDATA_W-1:0]   in_tdata,   // [0] restart, [7:1] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [swsg_pkg::OUT_TDATA_W-1:0]  out_tdata,  // [7:0] sample, [23:8] sample_index
  output logic                              out_tlast,  // last_of_buffer
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [swsg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [swsg_pkg::CFG_DATA_W-1:0]   cfg_data
);

  import swsg_pkg::*;

  swsg_cmd_t cmd;
  swsg_sts_t sts;
  logic      push;
  logic      out_free;

  logic [SAMPLE_W-1:0]    pend_sample;
  logic [INDEX_W-1:0]     pend_index;
  logic                   pend_last;

  logic                   out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_tlast_r;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_tvalid_r || out_tready;

  swsg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_restart (in_tdata[0]),
    .in_tready  (in_tready),
    .out_free   (out_free),
    .sts        (sts),
    .cmd        (cmd),
    .push       (push)
  );

  swsg_datapath #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .sts         (sts),
    .pend_sample (pend_sample),
    .pend_index  (pend_index),
    .pend_last   (pend_last)
  );

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (push) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_tdata_r <= {pend_index, pend_sample};
      out_tlast_r <= pend_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

FILE: rtl/swsg_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Uses no package items.
`timescale 1ns / 1ps

module swsg_div #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [COUNT_WIDTH-1:0] dividend,
  input  logic [COUNT_WIDTH-1:0] divisor,
  output logic                   done,
  output logic [COUNT_WIDTH-1:0] quot,
  output logic [COUNT_WIDTH-1:0] rem
);

  localparam int CW    = COUNT_WIDTH;
  localparam int CNT_W = $clog2(CW);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0]    rem_r, rem_nxt;
  logic [CW-1:0]    quot_r, quot_nxt;
  logic [CW-1:0]    dvs_r, dvs_nxt;
  logic [CW:0]      trial;
  logic [CW:0]      diff;
  logic             fits;

  always_comb begin
    trial    = {rem_r, quot_r[CW-1]};
    diff     = trial - {1'b0, dvs_r};
    fits     = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quot_nxt = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = fits ? diff[CW-1:0] : trial[CW-1:0];
      quot_nxt = {quot_r[CW-2:0], fits};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(CW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/swsg_datapath.sv
// Datapath: configuration registers, buffer geometry, period counters, duty product.
// Depends on swsg_pkg, swsg_div and the assertion macro header.
`timescale 1ns / 1ps
`include "square_wave_sample_generator_macros.svh"

module swsg_datapath #(
  parameter int COUNT_WIDTH = swsg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [swsg_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [swsg_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  swsg_pkg::swsg_cmd_t                  cmd,
  output swsg_pkg::swsg_sts_t                  sts,
  output logic [swsg_pkg::SAMPLE_W-1:0]        pend_sample,
  output logic [swsg_pkg::INDEX_W-1:0]         pend_index,
  output logic                                 pend_last
);

  import swsg_pkg::*;

  localparam int CW = COUNT_WIDTH;
  localparam int WW = (CW > 16) ? CW : 16;
  localparam int PW = CW + DUTY_W;
  localparam int HW = PW + 1 - DUTY_FRAC_W;

  logic [RATE_W-1:0]  sample_rate_r;
  logic [FREQ_W-1:0]  target_freq_r;
  logic [LEVEL_W-1:0] low_level_r;
  logic [LEVEL_W-1:0] high_level_r;
  logic [DUTY_W-1:0]  duty_r;

  logic [CW-1:0] fsc_r, fc_r, gcd_a_r, gcd_b_r;
  logic [CW-1:0] buf_len_r, per_cnt_r, q0_r, r0_r;
  logic [CW-1:0] pos_buf_r, per_idx_r, pos_per_r, per_len_r, high_len_r;
  logic [PW-1:0] prod_r;
  logic          setup_done_r;
  logic [SAMPLE_W-1:0] pend_sample_r;
  logic [INDEX_W-1:0]  pend_index_r;
  logic                pend_last_r;

  logic [WW-1:0] fs_w, fs_sat_w, f_w, half_w, f_c_w, cmax_w, pos_w;
  logic [CW-1:0] div_a, div_b, div_q, div_r;
  logic          div_done;

  logic          last;
  logic [CW-1:0] pip_next, idx_inc, idx_wrap, pos_buf_next;
  logic          pip_over;
  logic [CW:0]   r_sum;
  logic [CW-1:0] len_new;
  logic [PW:0]   rnd;
  logic [HW-1:0] h_raw;
  logic [CW-1:0] high_new;

  // clamp the rate and frequency
  always_comb begin
    cmax_w   = WW'({CW{1'b1}});
    fs_w     = (sample_rate_r < RATE_W'(2)) ? WW'(2) : WW'(sample_rate_r);
    fs_sat_w = (fs_w > cmax_w) ? cmax_w : fs_w;
    half_w   = fs_sat_w >> 1;
    f_w      = WW'(target_freq_r);
    if (f_w > half_w) begin
      f_c_w = half_w;
    end else if (f_w == '0) begin
      f_c_w = WW'(1);
    end else begin
      f_c_w = f_w;
    end
  end

  always_comb begin
    case (cmd.div_sel)
      DSEL_GCD: begin
        div_a = gcd_a_r;
        div_b = gcd_b_r;
      end
      DSEL_N: begin
        div_a = fsc_r;
        div_b = gcd_a_r;
      end
      DSEL_D: begin
        div_a = fc_r;
        div_b = gcd_a_r;
      end
      DSEL_Q: begin
        div_a = buf_len_r;
        div_b = per_cnt_r;
      end
      default: begin
        div_a = gcd_a_r;
        div_b = gcd_b_r;
      end
    endcase
  end

  swsg_div #(
    .COUNT_WIDTH(CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_r)
  );

  always_comb begin
    last         = (({1'b0, pos_buf_r} + 1'b1) >= {1'b0, buf_len_r});
    pos_buf_next = pos_buf_r + 1'b1;
    pip_next     = pos_per_r + 1'b1;
    pip_over     = (pip_next >= per_len_r);
    idx_inc      = per_idx_r + 1'b1;
    idx_wrap     = (idx_inc >= per_cnt_r) ? '0 : idx_inc;
    r_sum        = {1'b0, r0_r} + {1'b0, per_idx_r};
    len_new      = q0_r + CW'(r_sum >= {1'b0, per_cnt_r});
    rnd          = {1'b0, prod_r} + (PW+1)'(1 << (DUTY_FRAC_W - 1));
    h_raw        = rnd[PW:DUTY_FRAC_W];
    high_new     = (h_raw > HW'(per_len_r)) ? per_len_r : h_raw[CW-1:0];
    pos_w        = WW'(pos_buf_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_rate_r <= SAMPLE_RATE_RST;
      target_freq_r <= TARGET_FREQ_RST;
      low_level_r   <= LOW_LEVEL_RST;
      high_level_r  <= HIGH_LEVEL_RST;
      duty_r        <= DUTY_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SAMPLE_RATE: sample_rate_r <= cfg_data[RATE_W-1:0];
        REG_TARGET_FREQ: target_freq_r <= cfg_data[FREQ_W-1:0];
        REG_LOW_LEVEL:   low_level_r   <= cfg_data[LEVEL_W-1:0];
        REG_HIGH_LEVEL:  high_level_r  <= cfg_data[LEVEL_W-1:0];
        REG_DUTY_Q16:    duty_r        <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_done_r <= 1'b0;
      pos_buf_r    <= '0;
      per_idx_r    <= '0;
      pos_per_r    <= '0;
      per_len_r    <= '0;
      high_len_r   <= '0;
      buf_len_r    <= '0;
      per_cnt_r    <= '0;
    end else begin
      if (cmd.cap_n) begin
        buf_len_r <= div_q;
      end
      if (cmd.cap_d) begin
        per_cnt_r <= div_q;
      end
      if (cmd.cap_q) begin
        pos_buf_r    <= '0;
        per_idx_r    <= '0;
        setup_done_r <= 1'b1;
      end
      if (cmd.period_load) begin
        per_len_r <= len_new;
        pos_per_r <= '0;
      end
      if (cmd.high_load) begin
        high_len_r <= high_new;
      end
      if (cmd.step) begin
        if (last) begin
          pos_buf_r <= '0;
          per_idx_r <= '0;
        end else begin
          pos_buf_r <= pos_buf_next;
          pos_per_r <= pip_next;
          if (pip_over) begin
            per_idx_r <= idx_wrap;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_setup) begin
      fsc_r   <= fs_sat_w[CW-1:0];
      fc_r    <= f_c_w[CW-1:0];
      gcd_a_r <= fs_sat_w[CW-1:0];
      gcd_b_r <= f_c_w[CW-1:0];
    end else if (cmd.gcd_shift) begin
      gcd_a_r <= gcd_b_r;
      gcd_b_r <= div_r;
    end
    if (cmd.cap_q) begin
      q0_r <= div_q;
      r0_r <= div_r;
    end
    if (cmd.mul) begin
      prod_r <= PW'(per_len_r) * PW'(duty_r);
    end
    if (cmd.step) begin
      pend_sample_r <= (pos_per_r < high_len_r) ? high_level_r : low_level_r;
      pend_index_r  <= pos_w[INDEX_W-1:0];
      pend_last_r   <= last;
    end
  end

  always_comb begin
    sts.setup_done = setup_done_r;
    sts.gcd_b_zero = (gcd_b_r == '0);
    sts.div_done   = div_done;
    sts.new_period = last || pip_over;
  end

  assign pend_sample = pend_sample_r;
  assign pend_index  = pend_index_r;
  assign pend_last   = pend_last_r;

  `SWSG_ASSERT(a_step_ready, clk, rst_n, cmd.step |-> setup_done_r && per_cnt_r != '0, "step before geometry set up")
  `SWSG_ASSERT(a_step_high, clk, rst_n, cmd.step |-> high_len_r <= per_len_r, "high count exceeds period length")
  `SWSG_ASSERT(a_step_bounds, clk, rst_n, cmd.step |-> pos_buf_r < buf_len_r && per_idx_r < per_cnt_r, "buffer position or period index out of range")

endmodule

FILE: rtl/swsg_ctrl.sv
// Controller: sequences setup divisions, period loads and one step per input item.
// Depends on swsg_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "square_wave_sample_generator_macros.svh"

module swsg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  input  logic                in_restart,
  output logic                in_tready,
  input  logic                out_free,
  input  swsg_pkg::swsg_sts_t sts,
  output swsg_pkg::swsg_cmd_t cmd,
  output logic                push
);

  import swsg_pkg::*;

  swsg_state_t state_r, state_nxt;
  logic        step_done_r, step_done_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_done_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_done_r <= step_done_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_done_nxt = step_done_r;
    cmd           = '0;
    in_tready     = 1'b0;
    push          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          step_done_nxt = 1'b0;
          state_nxt     = (in_restart || !sts.setup_done) ? ST_SETUP : ST_STEP;
        end
      end
      ST_SETUP: begin
        cmd.load_setup = 1'b1;
        state_nxt      = ST_GCD_CHK;
      end
      ST_GCD_CHK: begin
        cmd.div_start = 1'b1;
        if (sts.gcd_b_zero) begin
          cmd.div_sel = DSEL_N;
          state_nxt   = ST_N_WAIT;
        end else begin
          cmd.div_sel = DSEL_GCD;
          state_nxt   = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (sts.div_done) begin
          cmd.gcd_shift = 1'b1;
          state_nxt     = ST_GCD_CHK;
        end
      end
      ST_N_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_n     = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel   = DSEL_D;
          state_nxt     = ST_D_WAIT;
        end
      end
      ST_D_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_d = 1'b1;
          state_nxt = ST_Q_START;
        end
      end
      ST_Q_START: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DSEL_Q;
        state_nxt     = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (sts.div_done) begin
          cmd.div_sel = DSEL_Q;
          cmd.cap_q   = 1'b1;
          state_nxt   = ST_PLOAD;
        end
      end
      ST_PLOAD: begin
        cmd.period_load = 1'b1;
        state_nxt       = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_HIGH;
      end
      ST_HIGH: begin
        cmd.high_load = 1'b1;
        state_nxt     = step_done_r ? ST_PUSH : ST_STEP;
      end
      ST_STEP: begin
        cmd.step      = 1'b1;
        step_done_nxt = 1'b1;
        state_nxt     = sts.new_period ? ST_PLOAD : ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `SWSG_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> state_r == ST_IDLE, "controller not idle after reset")
  `SWSG_ASSERT(a_accept_path, clk, rst_n, in_tvalid && in_tready |=> state_r == ST_SETUP || state_r == ST_STEP, "accepted item not started")
  `SWSG_ASSERT(a_push_stepped, clk, rst_n, state_r == ST_PUSH |-> step_done_r, "result pushed without a step")

endmodule

FILE: dv/square_wave_sample_checker.sv
// Checker for the square wave sample generator: tracks register writes, predicts
// every sample and compares it with the out_ channel. Depends on swsg_pkg.
`timescale 1ns / 1ps

module square_wave_sample_checker #(
  parameter int COUNT_WIDTH = swsg_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [swsg_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [swsg_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  logic                              out_tlast,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [swsg_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [swsg_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int                                fail_count,
  output int                                outstanding
);
  import swsg_pkg::*;

  localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_WIDTH) - 64'd1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic [INDEX_W-1:0]  index;
    logic                last;
  } sample_item_t;

  sample_item_t expected_samples[$];
  sample_item_t want_sample;

  longint unsigned rate_reg, freq_reg, low_reg, high_reg, duty_reg;
  longint unsigned buf_len, periods, buf_pos, period_idx, period_pos, period_len, high_len;
  bit geometry_valid;

  function automatic longint unsigned euclid(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic void load_period();
    longint unsigned len, h;
    len = (periods != 0) ? (buf_len + period_idx) / periods : 64'd0;
    h = (len * duty_reg + 64'd32768) >> DUTY_FRAC_W;
    if (h > len) h = len;
    period_len = len;
    high_len = h;
    period_pos = 0;
  endfunction

  function automatic void compute_geometry();
    longint unsigned fs, f, k;
    fs = rate_reg;
    if (fs < 2) fs = 2;
    if (fs > COUNT_MAX) fs = COUNT_MAX;
    f = freq_reg;
    if (f > fs / 2) f = fs / 2;
    if (f < 1) f = 1;
    k = euclid(fs, f);
    buf_len = fs / k;
    periods = f / k;
    buf_pos = 0;
    period_idx = 0;
    load_period();
    geometry_valid = 1'b1;
  endfunction

  function automatic void predict_sample(bit restart);
    sample_item_t s;
    bit last;
    if (restart || !geometry_valid) compute_geometry();
    last = (buf_pos + 1 >= buf_len);
    s.level = (period_pos < high_len) ? SAMPLE_W'(high_reg) : SAMPLE_W'(low_reg);
    s.index = INDEX_W'(buf_pos);
    s.last = last;
    expected_samples.push_back(s);
    if (last) begin
      buf_pos = 0;
      period_idx = 0;
      load_period();
    end else begin
      buf_pos = (buf_pos + 1) & COUNT_MAX;
      period_pos = (period_pos + 1) & COUNT_MAX;
      if (period_pos >= period_len) begin
        period_idx = (period_idx + 1) & COUNT_MAX;
        if (period_idx >= periods) period_idx = 0;
        load_period();
      end
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (fail_count < 100)
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rate_reg = 64'(SAMPLE_RATE_RST);
      freq_reg = 64'(TARGET_FREQ_RST);
      low_reg = 64'(LOW_LEVEL_RST);
      high_reg = 64'(HIGH_LEVEL_RST);
      duty_reg = 64'(DUTY_RST);
      buf_len = 0;
      periods = 0;
      buf_pos = 0;
      period_idx = 0;
      period_pos = 0;
      period_len = 0;
      high_len = 0;
      geometry_valid = 1'b0;
      expected_samples.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SAMPLE_RATE: rate_reg = 64'(cfg_data[RATE_W-1:0]);
          REG_TARGET_FREQ: freq_reg = 64'(cfg_data[FREQ_W-1:0]);
          REG_LOW_LEVEL:   low_reg = 64'(cfg_data[LEVEL_W-1:0]);
          REG_HIGH_LEVEL:  high_reg = 64'(cfg_data[LEVEL_W-1:0]);
          REG_DUTY_Q16:    duty_reg = 64'(cfg_data[DUTY_W-1:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_sample(in_tdata[0]);
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("unexpected item", 64'(out_tdata), 64'd0);
        end else begin
          want_sample = expected_samples.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== want_sample.level)
            report_mismatch("sample", 64'(out_tdata[SAMPLE_W-1:0]), 64'(want_sample.level));
          if (out_tdata[SAMPLE_W +: INDEX_W] !== want_sample.index)
            report_mismatch("sample_index", 64'(out_tdata[SAMPLE_W +: INDEX_W]),
                            64'(want_sample.index));
          if (out_tlast !== want_sample.last)
            report_mismatch("last_of_buffer", 64'(out_tlast), 64'(want_sample.last));
        end
      end
    end
    outstanding = expected_samples.size();
  end

endmodule

FILE: dv/testbench.sv
// Top of the square wave sample generator testbench: clock, reset, register
// programming, tick stimulus with random back-pressure and the final verdict.
// Depends on swsg_pkg, square_wave_sample_generator and square_wave_sample_checker.
`timescale 1ns / 1ps

module testbench;
  import swsg_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;
  logic                    out_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_INDEX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0]   cfg_data = '0;
  int                      fail_count;
  int                      outstanding;

  int send_idle_pct = 31;
  int recv_idle_pct = 56;
  int items_sent = 0;
  int stall_req = 0;
  int stall_seen = 0;
  int hold_left = 0;

  always #10 clk = ~clk;

  square_wave_sample_generator #(.COUNT_WIDTH(COUNT_WIDTH_DEF)) dut (.*);

  square_wave_sample_checker #(.COUNT_WIDTH(COUNT_WIDTH_DEF)) sample_monitor (.*);

  always @(negedge clk) begin
    if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      hold_left <= 300;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic send_tick(bit restart);
    int gap;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(restart);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    send_idle_pct = (items_sent < 420) ? 31 : (items_sent < 840) ? 56 : 0;
    recv_idle_pct = (items_sent < 420) ? 56 : (items_sent < 840) ? 31 : 0;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_ticks(int count, bit first_restart, int restart_pct);
    for (int i = 0; i < count; i++)
      send_tick((i == 0) ? first_restart : ($urandom_range(0, 99) < restart_pct));
  endtask

  // hold the sender until every sample is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic program_regs(bit [15:0] rate, bit [15:0] freq, bit [7:0] low,
                              bit [7:0] high, bit [16:0] duty);
    cfg_reg_t regs[5];
    bit [CFG_DATA_W-1:0] vals[5];
    regs = '{REG_SAMPLE_RATE, REG_TARGET_FREQ, REG_LOW_LEVEL, REG_HIGH_LEVEL, REG_DUTY_Q16};
    vals = '{CFG_DATA_W'(rate), CFG_DATA_W'(freq), CFG_DATA_W'(low), CFG_DATA_W'(high),
             CFG_DATA_W'(duty)};
    for (int i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    bit [15:0] rate, freq, half;
    bit [7:0]  low, high;
    bit [16:0] duty;
    int        r, count, phase;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset registers, geometry set up by the first tick alone
    send_ticks(4, 1'b0, 0);
    drain();
    // sample rate below two, frequency zero, full duty
    program_regs(16'd0, 16'd0, 8'hA5, 8'h5A, 17'd65536);
    send_ticks(3, 1'b1, 0);
    drain();
    // frequency above half the rate, duty above one
    program_regs(16'd7, 16'd65535, 8'd255, 8'd0, 17'd131071);
    send_ticks(7, 1'b1, 0);
    drain();
    // widest rate, zero duty, back-to-back restarts
    program_regs(16'd65535, 16'd65535, 8'd0, 8'd255, 17'd0);
    send_ticks(3, 1'b1, 100);
    drain();
    // half duty on odd period lengths rounds up
    program_regs(16'd9, 16'd2, 8'h0F, 8'hF0, 17'd32768);
    send_ticks(9, 1'b1, 0);

    phase = 0;
    while (items_sent < 1250) begin
      drain();
      r = $urandom_range(0, 99);
      if (r < 8) rate = 16'($urandom_range(0, 1));
      else if (r < 14) rate = 16'd65535;
      else if (r < 30) rate = 16'($urandom_range(2, 65535));
      else rate = 16'($urandom_range(2, 48));
      half = 16'(((rate < 16'd2) ? 16'd2 : rate) >> 1);
      r = $urandom_range(0, 99);
      if (r < 8) freq = 16'd0;
      else if (r < 16) freq = 16'd65535;
      else if (r < 30) freq = 16'($urandom_range(0, 65535));
      else freq = 16'($urandom_range(1, half));
      r = $urandom_range(0, 99);
      if (r < 10) duty = 17'd0;
      else if (r < 20) duty = 17'd65536;
      else if (r < 28) duty = 17'($urandom_range(65537, 131071));
      else duty = 17'($urandom_range(0, 65536));
      low = 8'($urandom_range(0, 255));
      high = 8'($urandom_range(0, 255));
      program_regs(rate, freq, low, high, duty);
      count = $urandom_range(40, 120);
      if (phase == 1) stall_req++;
      for (int i = 0; i < count; i++) begin
        if (i == 0) send_tick($urandom_range(0, 99) < 85);
        else send_tick($urandom_range(0, 99) < 3);
        if (i == count / 2 && (phase == 2 || $urandom_range(0, 3) == 0)) drain();
      end
      phase++;
    end
    drain();
    repeat (20) @(posedge clk);

    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #100000000;
    $display("FAIL");
    $finish;
  end

endmodule
